### rtl/bic_pkg.sv
// shared types and constants of the banked interrupt controller
`default_nettype none

package bic_pkg;

  localparam int unsigned BankW     = 32;
  localparam int unsigned BaseW     = 8;
  localparam int unsigned BaseFirst = 64;
  localparam int unsigned SrcCount  = 72;
  localparam int unsigned SrcW      = 7;
  localparam int unsigned InDataW   = 48;
  localparam int unsigned OutDataW  = 40;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_LINE  = 2'd2,
    OP_NOP   = 2'd3
  } opcode_e;

  typedef enum logic [3:0] {
    REG_PEND_BASE = 4'd0,
    REG_PEND_ONE  = 4'd1,
    REG_PEND_TWO  = 4'd2,
    REG_EN_ONE    = 4'd3,
    REG_EN_TWO    = 4'd4,
    REG_EN_BASE   = 4'd5,
    REG_DIS_ONE   = 4'd6,
    REG_DIS_TWO   = 4'd7,
    REG_DIS_BASE  = 4'd8
  } reg_sel_e;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [3:0]       reg_select;
    logic [BankW-1:0] write_data;
    logic [SrcW-1:0]  line_index;
    logic             line_level;
  } item_t;

  typedef struct packed {
    logic [BankW-1:0] en_one;
    logic [BankW-1:0] en_two;
    logic [BaseW-1:0] en_base;
    logic [BankW-1:0] raw_one;
    logic [BankW-1:0] raw_two;
    logic [BaseW-1:0] raw_base;
  } irq_state_t;

  typedef struct packed {
    logic [BankW-1:0] read_data;
    logic             any_pending;
    logic [SrcW-1:0]  next_source;
  } result_t;

endpackage

`default_nettype wire

### rtl/bic_state.sv
// enable and raw level registers with their update logic
`default_nettype none

module bic_state (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                upd_en_i,
  input  wire bic_pkg::item_t      item_i,
  output bic_pkg::irq_state_t      st_nxt_o
);

  bic_pkg::irq_state_t st_q, st_d;
  logic [bic_pkg::BankW-1:0] wdata;
  logic [bic_pkg::BaseW-1:0] wdata_base;

  assign wdata      = item_i.write_data;
  assign wdata_base = item_i.write_data[bic_pkg::BaseW-1:0];

  always_comb begin
    st_d = st_q;
    case (bic_pkg::opcode_e'(item_i.opcode))
      bic_pkg::OP_WRITE: begin
        unique case (bic_pkg::reg_sel_e'(item_i.reg_select))
          bic_pkg::REG_EN_ONE:   st_d.en_one  = st_q.en_one | wdata;
          bic_pkg::REG_EN_TWO:   st_d.en_two  = st_q.en_two | wdata;
          bic_pkg::REG_EN_BASE:  st_d.en_base = st_q.en_base | wdata_base;
          bic_pkg::REG_DIS_ONE:  st_d.en_one  = st_q.en_one & ~wdata;
          bic_pkg::REG_DIS_TWO:  st_d.en_two  = st_q.en_two & ~wdata;
          bic_pkg::REG_DIS_BASE: st_d.en_base = st_q.en_base & ~wdata_base;
          default: ;
        endcase
      end
      bic_pkg::OP_LINE: begin
        // out-of-range line numbers leave every bank alone
        if (item_i.line_index < bic_pkg::SrcW'(bic_pkg::BankW)) begin
          st_d.raw_one[item_i.line_index[4:0]] = item_i.line_level;
        end else if (item_i.line_index < bic_pkg::SrcW'(bic_pkg::BaseFirst)) begin
          st_d.raw_two[item_i.line_index[4:0]] = item_i.line_level;
        end else if (item_i.line_index < bic_pkg::SrcW'(bic_pkg::SrcCount)) begin
          st_d.raw_base[item_i.line_index[2:0]] = item_i.line_level;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (upd_en_i) begin
      st_q <= st_d;
    end
  end

  assign st_nxt_o = st_d;

endmodule

`default_nettype wire

### rtl/bic_result.sv
// read mux, pending masks and source priority
`default_nettype none

module bic_result (
  input  wire bic_pkg::item_t      item_i,
  input  wire bic_pkg::irq_state_t st_i,
  output bic_pkg::result_t         res_o
);

  logic [bic_pkg::BankW-1:0] pend_one, pend_two;
  logic [bic_pkg::BaseW-1:0] base_hits;
  logic [4:0]                low_one, low_two;
  logic [2:0]                low_base;
  logic [bic_pkg::BankW-1:0] rdata;

  assign pend_one  = st_i.raw_one & st_i.en_one;
  assign pend_two  = st_i.raw_two & st_i.en_two;
  assign base_hits = st_i.raw_base & st_i.en_base;

  // lowest set bit wins
  always_comb begin
    low_one  = '0;
    low_two  = '0;
    low_base = '0;
    for (int i = bic_pkg::BankW - 1; i >= 0; i--) begin
      if (pend_one[i]) low_one = 5'(i);
      if (pend_two[i]) low_two = 5'(i);
    end
    for (int i = bic_pkg::BaseW - 1; i >= 0; i--) begin
      if (base_hits[i]) low_base = 3'(i);
    end
  end

  always_comb begin
    rdata = '0;
    if (bic_pkg::opcode_e'(item_i.opcode) == bic_pkg::OP_READ) begin
      unique case (bic_pkg::reg_sel_e'(item_i.reg_select)) inside
        bic_pkg::REG_PEND_BASE: rdata = {22'd0, |pend_two, |pend_one, base_hits};
        bic_pkg::REG_PEND_ONE:  rdata = pend_one;
        bic_pkg::REG_PEND_TWO:  rdata = pend_two;
        bic_pkg::REG_EN_ONE,
        bic_pkg::REG_DIS_ONE:   rdata = st_i.en_one;
        bic_pkg::REG_EN_TWO,
        bic_pkg::REG_DIS_TWO:   rdata = st_i.en_two;
        bic_pkg::REG_EN_BASE,
        bic_pkg::REG_DIS_BASE:  rdata = {24'd0, st_i.en_base};
        default:                rdata = '0;
      endcase
    end
  end

  always_comb begin
    res_o.read_data   = rdata;
    res_o.any_pending = 1'b1;
    if (|pend_one) begin
      res_o.next_source = {2'b00, low_one};
    end else if (|pend_two) begin
      res_o.next_source = bic_pkg::SrcW'(bic_pkg::BankW) | {2'b00, low_two};
    end else if (|base_hits) begin
      res_o.next_source = bic_pkg::SrcW'(bic_pkg::BaseFirst) | {4'd0, low_base};
    end else begin
      res_o.next_source = '0;
      res_o.any_pending = 1'b0;
    end
  end

endmodule

`default_nettype wire

### rtl/banked_interrupt_controller.sv
// top level of the banked interrupt controller with input and result registers
//
//  channel  dir  width  contents
//  s_axis   in   48     register access or line event
//  m_axis   out  40     read data, pending flag, next source
//
//  one item per cycle unless m_axis stalls; each result is held in an output register
//  the state update and the result both happen as the item leaves the input register
//  reset clears all enables and raw levels, no clearing pass
//  a stalled result holds while the input register still takes one more item
`default_nettype none

module banked_interrupt_controller (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [1:0] opcode, [5:2] reg_select, [37:6] write_data, [44:38] line_index,
  // [45] line_level, [47:46] zero
  input  wire logic [47:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [31:0] read_data, [32] any_pending, [39:33] next_source
  output logic [39:0]      m_axis_tdata
);

  logic                   in_vld_q;
  bic_pkg::item_t         in_q;
  logic                   out_vld_q;
  bic_pkg::result_t       out_q;
  logic                   advance;
  bic_pkg::irq_state_t    st_nxt;
  bic_pkg::result_t       res;

  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_q.opcode     <= s_axis_tdata[1:0];
      in_q.reg_select <= s_axis_tdata[5:2];
      in_q.write_data <= s_axis_tdata[37:6];
      in_q.line_index <= s_axis_tdata[44:38];
      in_q.line_level <= s_axis_tdata[45];
    end
  end

  bic_state u_state (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .upd_en_i (advance),
    .item_i   (in_q),
    .st_nxt_o (st_nxt)
  );

  bic_result u_result (
    .item_i (in_q),
    .st_i   (st_nxt),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_q.next_source, out_q.any_pending, out_q.read_data};

endmodule

`default_nettype wire

### rtl/bic_checker.sv
// port-level checks of the banked interrupt controller and their bind
`default_nettype none

module bic_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic [47:0] s_axis_tdata,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [39:0] m_axis_tdata
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[32] |-> m_axis_tdata[39:33] == 7'd0)
    else $error("next source set with nothing pending");

  a_src_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[39:33] < 7'd72)
    else $error("next source out of range");

  // input is only held off behind a stalled result
  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input held off without a stalled result");

endmodule

bind banked_interrupt_controller bic_checker u_bic_checker (.*);

`default_nettype wire

### verif/banked_interrupt_controller_tb.sv
// self-checking testbench for the banked interrupt controller
`timescale 1ns / 100ps

module banked_interrupt_controller_tb;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned DrainCycles = 4;

  typedef enum logic [2:0] {
    PACE_FREE,
    PACE_SRC_GAPS,
    PACE_SINK_STALLS,
    PACE_BOTH,
    PACE_HOLD
  } pace_e;

  typedef struct {
    logic [bic_pkg::InDataW-1:0] tdata;
    pace_e                       pace;
  } access_t;

  logic                         clk_i         = 1'b0;
  logic                         rst_ni        = 1'b0;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [bic_pkg::InDataW-1:0]  s_axis_tdata  = '0;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  logic [bic_pkg::OutDataW-1:0] m_axis_tdata;

  access_t           pending_items[$];
  bic_pkg::result_t  expected_results[$];
  pace_e             cur_pace    = PACE_FREE;
  logic              in_taken    = 1'b0;
  int unsigned       hold_left   = 0;
  logic              hold_done   = 1'b0;
  int unsigned       error_count = 0;
  int unsigned       cycle_count = 0;

  // controller state as the testbench sees it
  logic [bic_pkg::BankW-1:0] en_one   = '0;
  logic [bic_pkg::BankW-1:0] en_two   = '0;
  logic [bic_pkg::BaseW-1:0] en_base  = '0;
  logic [bic_pkg::BankW-1:0] raw_one  = '0;
  logic [bic_pkg::BankW-1:0] raw_two  = '0;
  logic [bic_pkg::BaseW-1:0] raw_base = '0;

  banked_interrupt_controller i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [bic_pkg::SrcW-1:0] lowest_set(logic [bic_pkg::BankW-1:0] v);
    logic [bic_pkg::SrcW-1:0] n;
    n = '0;
    for (int i = bic_pkg::BankW - 1; i >= 0; i--) begin
      if (v[i]) n = bic_pkg::SrcW'(i);
    end
    return n;
  endfunction

  // updates the controller state for one item and returns its result
  function automatic bic_pkg::result_t apply_access(logic [bic_pkg::InDataW-1:0] d);
    bic_pkg::opcode_e          op;
    logic [3:0]                sel;
    logic [bic_pkg::BankW-1:0] mask;
    logic [bic_pkg::SrcW-1:0]  idx;
    logic                      lvl;
    logic [bic_pkg::BankW-1:0] p1;
    logic [bic_pkg::BankW-1:0] p2;
    logic [bic_pkg::BaseW-1:0] pb;
    bic_pkg::result_t          r;
    op   = bic_pkg::opcode_e'(d[1:0]);
    sel  = d[5:2];
    mask = d[37:6];
    idx  = d[44:38];
    lvl  = d[45];
    r    = '0;
    if (op == bic_pkg::OP_WRITE) begin
      case (sel)
        bic_pkg::REG_EN_ONE:   en_one  = en_one | mask;
        bic_pkg::REG_EN_TWO:   en_two  = en_two | mask;
        bic_pkg::REG_EN_BASE:  en_base = en_base | mask[bic_pkg::BaseW-1:0];
        bic_pkg::REG_DIS_ONE:  en_one  = en_one & ~mask;
        bic_pkg::REG_DIS_TWO:  en_two  = en_two & ~mask;
        bic_pkg::REG_DIS_BASE: en_base = en_base & ~mask[bic_pkg::BaseW-1:0];
        default: ;
      endcase
    end else if (op == bic_pkg::OP_LINE && idx < bic_pkg::SrcCount) begin
      if (idx < bic_pkg::BankW) raw_one[idx[4:0]] = lvl;
      else if (idx < bic_pkg::BaseFirst) raw_two[idx[4:0]] = lvl;
      else raw_base[idx[2:0]] = lvl;
    end
    p1 = raw_one & en_one;
    p2 = raw_two & en_two;
    pb = raw_base & en_base;
    if (op == bic_pkg::OP_READ) begin
      case (sel) inside
        bic_pkg::REG_PEND_BASE: r.read_data = {22'b0, |p2, |p1, pb};
        bic_pkg::REG_PEND_ONE:  r.read_data = p1;
        bic_pkg::REG_PEND_TWO:  r.read_data = p2;
        bic_pkg::REG_EN_ONE, bic_pkg::REG_DIS_ONE:   r.read_data = en_one;
        bic_pkg::REG_EN_TWO, bic_pkg::REG_DIS_TWO:   r.read_data = en_two;
        bic_pkg::REG_EN_BASE, bic_pkg::REG_DIS_BASE: r.read_data = {24'b0, en_base};
        default:                r.read_data = '0;
      endcase
    end
    r.any_pending = 1'b1;
    if (|p1) r.next_source = lowest_set(p1);
    else if (|p2) r.next_source = bic_pkg::SrcW'(bic_pkg::BankW) + lowest_set(p2);
    else if (|pb) r.next_source = bic_pkg::SrcW'(bic_pkg::BaseFirst) + lowest_set({24'b0, pb});
    else r.any_pending = 1'b0;
    return r;
  endfunction

  function automatic logic draw_idle(pace_e p, logic sink);
    int unsigned pct;
    case (p)
      PACE_SRC_GAPS:    pct = sink ? 0 : 88;
      PACE_SINK_STALLS: pct = sink ? 88 : 0;
      PACE_BOTH:        pct = 16;
      default:          pct = 0;
    endcase
    return $urandom_range(0, 99) < pct;
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  task automatic queue_access(bic_pkg::opcode_e op, logic [3:0] sel,
                              logic [bic_pkg::BankW-1:0] mask,
                              logic [bic_pkg::SrcW-1:0] idx, logic lvl, pace_e p);
    access_t a;
    a.tdata = {2'b00, lvl, idx, mask, sel, op};
    a.pace  = p;
    pending_items.push_back(a);
  endtask

  task automatic queue_random(pace_e p);
    int unsigned               pick;
    bic_pkg::opcode_e          op;
    logic [bic_pkg::BankW-1:0] mask;
    logic [3:0]                sel;
    logic [bic_pkg::SrcW-1:0]  idx;
    pick = $urandom_range(0, 99);
    case ($urandom_range(0, 4))
      0: mask = $urandom;
      1: mask = 32'h1 << $urandom_range(0, 31);
      2: mask = $urandom & $urandom & $urandom;
      3: mask = '1;
      default: mask = $urandom_range(0, 1) ? '0 : ~(32'h1 << $urandom_range(0, 31));
    endcase
    sel = ($urandom_range(0, 99) < 92) ? 4'($urandom_range(0, 8)) : 4'($urandom_range(9, 15));
    idx = ($urandom_range(0, 99) < 92) ? 7'($urandom_range(0, 71))
                                       : 7'($urandom_range(72, 127));
    if (pick < 30) op = bic_pkg::OP_WRITE;
    else if (pick < 62) op = bic_pkg::OP_READ;
    else if (pick < 96) op = bic_pkg::OP_LINE;
    else op = bic_pkg::OP_NOP;
    // lines lean toward high so pending bits build up
    queue_access(op, sel, mask, idx, $urandom_range(0, 99) < 60, p);
  endtask

  // sender: offers the next item once the current one is taken
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || in_taken)) begin
      if (pending_items.size() != 0 && !draw_idle(pending_items[0].pace, 1'b0)) begin
        s_axis_tdata  <= pending_items[0].tdata;
        cur_pace      <= pending_items[0].pace;
        s_axis_tvalid <= 1'b1;
        void'(pending_items.pop_front());
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus one long hold-off to back up the pipeline
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (cur_pace == PACE_HOLD && !hold_done) begin
      m_axis_tready <= 1'b0;
      hold_left     <= HoldCycles;
      hold_done     <= 1'b1;
    end else begin
      m_axis_tready <= !draw_idle(cur_pace, 1'b1);
    end
  end

  always @(posedge clk_i) begin : monitor
    bic_pkg::result_t got;
    bic_pkg::result_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.read_data   = m_axis_tdata[31:0];
        got.any_pending = m_axis_tdata[32];
        got.next_source = m_axis_tdata[39:33];
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result %h", m_axis_tdata));
        end else begin
          want = expected_results.pop_front();
          if (got.read_data !== want.read_data)
            report_mismatch($sformatf("read_data %h, want %h", got.read_data, want.read_data));
          if (got.any_pending !== want.any_pending)
            report_mismatch($sformatf("any_pending %b, want %b",
                                      got.any_pending, want.any_pending));
          if (got.next_source !== want.next_source)
            report_mismatch($sformatf("next_source %0d, want %0d",
                                      got.next_source, want.next_source));
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_results.push_back(apply_access(s_axis_tdata));
    end
    in_taken <= s_axis_tvalid && s_axis_tready;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    // reset state: every register
    for (int s = bic_pkg::REG_PEND_BASE; s <= bic_pkg::REG_DIS_BASE; s++)
      queue_access(bic_pkg::OP_READ, 4'(s), '0, '0, 1'b0, PACE_FREE);
    queue_access(bic_pkg::OP_READ, 4'd15, '1, '0, 1'b0, PACE_FREE);
    // enable everything; base only keeps the low byte
    queue_access(bic_pkg::OP_WRITE, bic_pkg::REG_EN_ONE, '1, '0, 1'b0, PACE_FREE);
    queue_access(bic_pkg::OP_WRITE, bic_pkg::REG_EN_TWO, '1, '0, 1'b0, PACE_FREE);
    queue_access(bic_pkg::OP_WRITE, bic_pkg::REG_EN_BASE, '1, '0, 1'b0, PACE_FREE);
    queue_access(bic_pkg::OP_LINE, '0, '0, 7'd71, 1'b1, PACE_FREE);
    queue_access(bic_pkg::OP_LINE, '0, '0, 7'd64, 1'b1, PACE_FREE);
    queue_access(bic_pkg::OP_LINE, '0, '0, 7'd63, 1'b1, PACE_FREE);
    queue_access(bic_pkg::OP_LINE, '0, '0, 7'd32, 1'b1, PACE_FREE);
    queue_access(bic_pkg::OP_LINE, '0, '0, 7'd31, 1'b1, PACE_FREE);
    // out-of-range lines are ignored
    queue_access(bic_pkg::OP_LINE, '0, '1, 7'd72, 1'b1, PACE_FREE);
    queue_access(bic_pkg::OP_LINE, '0, '1, 7'd127, 1'b1, PACE_FREE);
    queue_access(bic_pkg::OP_READ, bic_pkg::REG_PEND_BASE, '0, '0, 1'b0, PACE_FREE);
    queue_access(bic_pkg::OP_READ, bic_pkg::REG_PEND_ONE, '0, '0, 1'b0, PACE_FREE);
    // drop bank one so bank two wins, then bank two so base wins
    queue_access(bic_pkg::OP_LINE, '0, '0, 7'd31, 1'b0, PACE_FREE);
    queue_access(bic_pkg::OP_WRITE, bic_pkg::REG_DIS_TWO, '1, '0, 1'b0, PACE_FREE);
    // writes to pend and unknown registers change nothing
    queue_access(bic_pkg::OP_WRITE, bic_pkg::REG_PEND_BASE, '1, '0, 1'b1, PACE_FREE);
    queue_access(bic_pkg::OP_WRITE, 4'd15, '1, '1, 1'b1, PACE_FREE);
    queue_access(bic_pkg::OP_NOP, bic_pkg::REG_EN_ONE, '1, '1, 1'b1, PACE_FREE);
    queue_access(bic_pkg::OP_WRITE, bic_pkg::REG_DIS_BASE, 32'hffff_ff80, '0, 1'b0,
                 PACE_FREE);
    queue_access(bic_pkg::OP_READ, bic_pkg::REG_DIS_BASE, '0, '0, 1'b0, PACE_FREE);
    queue_access(bic_pkg::OP_READ, bic_pkg::REG_PEND_BASE, '0, '0, 1'b0, PACE_FREE);

    repeat (140) queue_random(PACE_FREE);
    repeat (130) queue_random(PACE_SRC_GAPS);
    repeat (130) queue_random(PACE_SINK_STALLS);
    repeat (130) queue_random(PACE_BOTH);
    repeat (60) queue_random(PACE_HOLD);
    repeat (110) queue_random(PACE_FREE);

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    wait (pending_items.size() == 0 && !s_axis_tvalid);
    wait (expected_results.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### banked_interrupt_controller.f
rtl/bic_pkg.sv
rtl/bic_state.sv
rtl/bic_result.sv
rtl/banked_interrupt_controller.sv
rtl/bic_checker.sv
verif/banked_interrupt_controller_tb.sv
